// ===== design/fpc_pkg.sv =====
// Shared types and constants for the frustum plane cull test block.
package fpc_pkg;

    localparam int NUM_PLANES_DEF = 6;
    localparam int NUM_COEF       = 4;
    localparam int NUM_CORNERS    = 8;
    localparam int CMD_W          = 3;
    localparam int PLANE_W        = 3;
    localparam int CIDX_W         = 2;
    localparam int COEF_W         = 32;
    localparam int RAD_W          = 31;
    localparam int FRAC_W         = 16;
    localparam int PROD_W         = 2 * COEF_W;
    localparam int BIAS_W         = RAD_W + FRAC_W + 1;
    localparam int XY_W           = PROD_W + 1;
    localparam int ZD_W           = PROD_W + 2;
    localparam int SUM_W          = PROD_W + 3;

    localparam logic [CIDX_W-1:0] COEF_A = 2'd0;
    localparam logic [CIDX_W-1:0] COEF_B = 2'd1;
    localparam logic [CIDX_W-1:0] COEF_C = 2'd2;
    localparam logic [CIDX_W-1:0] COEF_D = 2'd3;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD       = 3'd0,
        CMD_POINT      = 3'd1,
        CMD_SPHERE     = 3'd2,
        CMD_BOX_ISECT  = 3'd3,
        CMD_BOX_INSIDE = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_WAIT,
        S_OUT
    } t_state;

    typedef struct packed {
        logic               load_coef;
        logic               start;
        logic               issue;
        logic               last;
        logic [PLANE_W-1:0] plane;
        logic               out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic done;
    } t_dp_sts;

endpackage

// ===== design/fpc_ctrl.sv =====
// Controller: transaction handshakes, plane sequencing and result register control.
module fpc_ctrl #(
    parameter int NUM_PLANES = fpc_pkg::NUM_PLANES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [fpc_pkg::CMD_W-1:0]  i_command,
    output logic                       o_valid,
    input  logic                       i_ready,
    output fpc_pkg::t_dp_cmd           o_cmd,
    input  fpc_pkg::t_dp_sts           i_sts
);
    import fpc_pkg::*;

    localparam int PIDX_W = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;

    t_state            r_state, n_state;
    logic [PIDX_W-1:0] r_plane, n_plane;
    logic              r_out_vld, n_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_plane   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_plane   <= n_plane;
            r_out_vld <= n_out_vld;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_plane   = r_plane;
        n_out_vld = r_out_vld && !i_ready;
        o_cmd     = '0;
        o_ready   = (r_state == S_IDLE) && i_rst_n;
        case (r_state)
            S_IDLE: begin
                if (i_valid && o_ready) begin
                    case (t_cmd'(i_command))
                        CMD_LOAD: begin
                            o_cmd.load_coef = 1'b1;
                        end
                        CMD_POINT, CMD_SPHERE, CMD_BOX_ISECT, CMD_BOX_INSIDE: begin
                            o_cmd.start = 1'b1;
                            n_plane     = '0;
                            n_state     = S_RUN;
                        end
                        default: ;
                    endcase
                end
            end
            S_RUN: begin
                o_cmd.issue = 1'b1;
                o_cmd.plane = PLANE_W'(r_plane);
                o_cmd.last  = (r_plane == PIDX_W'(NUM_PLANES - 1));
                if (o_cmd.last) begin
                    n_state = S_WAIT;
                end else begin
                    n_plane = r_plane + 1'b1;
                end
            end
            S_WAIT: begin
                if (i_sts.done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_vld || i_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_vld      = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_valid = r_out_vld;

endmodule

// ===== design/fpc_dp.sv =====
// Datapath: plane table, product stage, partial sum stage and corner sign test.
module fpc_dp #(
    parameter int NUM_PLANES = fpc_pkg::NUM_PLANES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  fpc_pkg::t_dp_cmd                  i_cmd,
    output fpc_pkg::t_dp_sts                  o_sts,
    input  logic [fpc_pkg::CMD_W-1:0]         i_command,
    input  logic [fpc_pkg::PLANE_W-1:0]       i_plane_index,
    input  logic [fpc_pkg::CIDX_W-1:0]        i_coef_index,
    input  logic signed [fpc_pkg::COEF_W-1:0] i_coef_value,
    input  logic signed [fpc_pkg::COEF_W-1:0] i_x_a,
    input  logic signed [fpc_pkg::COEF_W-1:0] i_y_a,
    input  logic signed [fpc_pkg::COEF_W-1:0] i_z_a,
    input  logic signed [fpc_pkg::COEF_W-1:0] i_x_b,
    input  logic signed [fpc_pkg::COEF_W-1:0] i_y_b,
    input  logic signed [fpc_pkg::COEF_W-1:0] i_z_b,
    input  logic [fpc_pkg::RAD_W-1:0]         i_sphere_radius,
    output logic                              o_visible
);
    import fpc_pkg::*;

    localparam int PIDX_W = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;

    logic signed [COEF_W-1:0] r_coef [NUM_PLANES][NUM_COEF];

    t_cmd                     r_cmd;
    logic signed [COEF_W-1:0] r_xa, r_ya, r_za, r_xb, r_yb, r_zb;
    logic [RAD_W-1:0]         r_rad;

    logic [PIDX_W-1:0]        w_pl;
    logic signed [COEF_W-1:0] w_a, w_b, w_c, w_d;
    logic signed [BIAS_W-1:0] w_bias;

    logic                     r_s1_vld, r_s1_last;
    logic signed [PROD_W-1:0] r_pax [2];
    logic signed [PROD_W-1:0] r_pby [2];
    logic signed [PROD_W-1:0] r_pcz [2];
    logic signed [COEF_W-1:0] r_pd;

    logic                     r_s2_vld, r_s2_last;
    logic signed [XY_W-1:0]   r_xy [4];
    logic signed [ZD_W-1:0]   r_zd [2];

    logic signed [SUM_W-1:0]  w_sum [NUM_CORNERS];
    logic [NUM_CORNERS-1:0]   w_le;
    logic                     w_rej;

    logic                     r_visible, r_done, r_out_vis;

    // coefficient table
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_coef && ({1'b0, i_plane_index} < (PLANE_W + 1)'(NUM_PLANES))) begin
            r_coef[i_plane_index[PIDX_W-1:0]][i_coef_index] <= i_coef_value;
        end
    end

    // operand capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_cmd <= t_cmd'(i_command);
            r_xa  <= i_x_a;
            r_ya  <= i_y_a;
            r_za  <= i_z_a;
            r_xb  <= i_x_b;
            r_yb  <= i_y_b;
            r_zb  <= i_z_b;
            r_rad <= i_sphere_radius;
        end
    end

    assign w_pl   = i_cmd.plane[PIDX_W-1:0];
    assign w_a    = r_coef[w_pl][COEF_A];
    assign w_b    = r_coef[w_pl][COEF_B];
    assign w_c    = r_coef[w_pl][COEF_C];
    assign w_d    = r_coef[w_pl][COEF_D];
    assign w_bias = (r_cmd == CMD_SPHERE) ? $signed({1'b0, r_rad, {FRAC_W{1'b0}}}) : '0;

    // stage 1: products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s1_last <= 1'b0;
        end else begin
            r_s1_vld  <= i_cmd.issue;
            r_s1_last <= i_cmd.last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pax[0] <= w_a * r_xa;
        r_pax[1] <= w_a * r_xb;
        r_pby[0] <= w_b * r_ya;
        r_pby[1] <= w_b * r_yb;
        r_pcz[0] <= w_c * r_za;
        r_pcz[1] <= w_c * r_zb;
        r_pd     <= w_d;
    end

    // stage 2: xy sums and z + d + bias sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld  <= 1'b0;
            r_s2_last <= 1'b0;
        end else begin
            r_s2_vld  <= r_s1_vld;
            r_s2_last <= r_s1_vld && r_s1_last;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 4; j++) begin
            r_xy[j] <= XY_W'(r_pax[j[0]]) + XY_W'(r_pby[j[1]]);
        end
        for (int m = 0; m < 2; m++) begin
            r_zd[m] <= ZD_W'(r_pcz[m]) + ZD_W'($signed({r_pd, {FRAC_W{1'b0}}}))
                     + ZD_W'(w_bias);
        end
    end

    // stage 3: corner sums and plane verdict
    always_comb begin
        for (int k = 0; k < NUM_CORNERS; k++) begin
            w_sum[k] = SUM_W'(r_xy[k[1:0]]) + SUM_W'(r_zd[k[2]]);
            w_le[k]  = w_sum[k][SUM_W-1] || (w_sum[k] == '0);
        end
        case (r_cmd)
            CMD_POINT, CMD_SPHERE: w_rej = w_le[0];
            CMD_BOX_ISECT:         w_rej = &w_le;
            CMD_BOX_INSIDE:        w_rej = |w_le;
            default:               w_rej = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_visible <= 1'b1;
        end else if (r_s2_vld && w_rej) begin
            r_visible <= 1'b0;
        end
        if (i_cmd.out_load) begin
            r_out_vis <= r_visible;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_s2_last;
        end
    end

    assign o_sts.done = r_done;
    assign o_visible  = r_out_vis;

endmodule

// ===== design/frustum_plane_cull_test.sv =====
// Top level of the six-plane frustum cull test block.
// Plane coefficients are loaded one per transaction; a load gives no result.
// A point, sphere or box test walks the plane table one plane per cycle
// through a multiply stage and two add stages, all eight box corners in
// parallel. The next transaction is accepted only after the verdict of the
// test has been loaded into the result register, and not while the test runs.
// The result register frees the input side: a new transaction is taken while
// the previous verdict still waits on the output. All arithmetic is exact
// signed Q16.16 with full-width products and sums.
module frustum_plane_cull_test #(
    parameter int NUM_PLANES = fpc_pkg::NUM_PLANES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [fpc_pkg::CMD_W-1:0]         i_command,
    input  logic [fpc_pkg::PLANE_W-1:0]       i_plane_index,
    input  logic [fpc_pkg::CIDX_W-1:0]        i_coef_index,
    input  logic signed [fpc_pkg::COEF_W-1:0] i_coef_value,
    input  logic signed [fpc_pkg::COEF_W-1:0] i_x_a,
    input  logic signed [fpc_pkg::COEF_W-1:0] i_y_a,
    input  logic signed [fpc_pkg::COEF_W-1:0] i_z_a,
    input  logic signed [fpc_pkg::COEF_W-1:0] i_x_b,
    input  logic signed [fpc_pkg::COEF_W-1:0] i_y_b,
    input  logic signed [fpc_pkg::COEF_W-1:0] i_z_b,
    input  logic [fpc_pkg::RAD_W-1:0]         i_sphere_radius,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic                              o_visible
);
    import fpc_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    fpc_ctrl #(
        .NUM_PLANES (NUM_PLANES)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_command (i_command),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_cmd     (w_cmd),
        .i_sts     (w_sts)
    );

    fpc_dp #(
        .NUM_PLANES (NUM_PLANES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_command       (i_command),
        .i_plane_index   (i_plane_index),
        .i_coef_index    (i_coef_index),
        .i_coef_value    (i_coef_value),
        .i_x_a           (i_x_a),
        .i_y_a           (i_y_a),
        .i_z_a           (i_z_a),
        .i_x_b           (i_x_b),
        .i_y_b           (i_y_b),
        .i_z_b           (i_z_b),
        .i_sphere_radius (i_sphere_radius),
        .o_visible       (o_visible)
    );

endmodule

// ===== design/fpc_checker.sv =====
// Port-level assertion checker for the frustum plane cull test block, with its bind.
module fpc_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_valid,
    input logic                              o_ready,
    input logic [fpc_pkg::CMD_W-1:0]         i_command,
    input logic                              o_valid,
    input logic                              i_ready,
    input logic                              o_visible
);
    import fpc_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_visible))
        else $error("result changed or dropped while stalled");

    // a load transaction never raises a result
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && (i_command == CMD_LOAD) |=> !$rose(o_valid))
        else $error("load transaction produced a result");

    // a test transaction occupies the block
    a_test_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && ((i_command == CMD_POINT) || (i_command == CMD_SPHERE)
            || (i_command == CMD_BOX_ISECT) || (i_command == CMD_BOX_INSIDE))
        |=> !o_ready)
        else $error("block ready right after accepting a test");

    // a new result only appears at the end of a test
    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> !$past(o_ready))
        else $error("result raised without a test in flight");

endmodule

bind frustum_plane_cull_test fpc_checker u_fpc_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_valid   (i_valid),
    .o_ready   (o_ready),
    .i_command (i_command),
    .o_valid   (o_valid),
    .i_ready   (i_ready),
    .o_visible (o_visible)
);

// ===== tb/frustum_plane_cull_test_tb.sv =====
// Self-checking testbench for the frustum plane cull test block.
module frustum_plane_cull_test_tb;

    import fpc_pkg::*;

    localparam int NUM_PLANES  = NUM_PLANES_DEF;
    localparam int LATENCY     = NUM_PLANES + 5;
    localparam int RAND_ITEMS  = 1850;
    localparam int STALL_LIMIT = 4000;
    localparam int LONG_HOLD   = 400;
    localparam int MAX_PRINTS  = 50;
    localparam int DIR_ROWS    = 27;

    localparam logic [CMD_W-1:0] CMD_RSVD5 = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RSVD6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSVD7 = 3'd7;
    localparam logic [PLANE_W-1:0] PLANE_TOP = '1;

    localparam logic signed [COEF_W-1:0] QZERO = 32'sh0000_0000;
    localparam logic signed [COEF_W-1:0] QONE  = 32'sh0001_0000;
    localparam logic signed [COEF_W-1:0] QMIN  = 32'sh8000_0000;
    localparam logic signed [COEF_W-1:0] QMAX  = 32'sh7FFF_FFFF;
    localparam logic [RAD_W-1:0] RZERO = '0;
    localparam logic [RAD_W-1:0] RMAX  = '1;

    localparam int unsigned COORD_SPAN = 30 * 65536;
    localparam int unsigned COEF_SPAN  = 65536;
    localparam int unsigned D_SPAN     = 200 * 65536;
    localparam int unsigned RAD_SPAN   = 20 * 65536;

    typedef enum bit {BY_PRED, TYPED} t_check;

    typedef struct {
        logic [CMD_W-1:0]          cmd;
        logic [PLANE_W-1:0]        plane;
        logic [CIDX_W-1:0]         cidx;
        logic signed [COEF_W-1:0]  coef;
        logic signed [COEF_W-1:0]  xa, ya, za, xb, yb, zb;
        logic [RAD_W-1:0]          rad;
    } t_cull_txn;

    typedef struct {
        logic [CMD_W-1:0]          cmd;
        logic [PLANE_W-1:0]        plane;
        logic [CIDX_W-1:0]         cidx;
        logic signed [COEF_W-1:0]  coef;
        logic signed [COEF_W-1:0]  xa, ya, za, xb, yb, zb;
        logic [RAD_W-1:0]          rad;
        t_check                    chk;
        bit                        vis;
    } t_dir_row;

    // Planes start as a = b = c = 0, d = 1.0 before this table runs.
    t_dir_row dir_tbl [DIR_ROWS] = '{
        '{CMD_POINT, 3'd0, COEF_A, QZERO, QZERO, QZERO, QZERO, QZERO, QZERO, QZERO,
          RZERO, TYPED, 1'b1},
        '{CMD_SPHERE, 3'd0, COEF_A, QZERO, QZERO, QZERO, QZERO, QZERO, QZERO, QZERO,
          RZERO, TYPED, 1'b1},
        '{CMD_BOX_ISECT, 3'd0, COEF_A, QZERO, QMIN, QMIN, QMIN, QMAX, QMAX, QMAX,
          RZERO, TYPED, 1'b1},
        '{CMD_BOX_INSIDE, 3'd0, COEF_A, QZERO, QMIN, QMIN, QMIN, QMAX, QMAX, QMAX,
          RZERO, TYPED, 1'b1},
        // plane 0 becomes all zero: v = 0 sits on the reject side
        '{CMD_LOAD, 3'd0, COEF_D, QZERO, QZERO, QZERO, QZERO, QZERO, QZERO, QZERO,
          RZERO, BY_PRED, 1'b0},
        '{CMD_POINT, 3'd0, COEF_A, QZERO, QZERO, QZERO, QZERO, QZERO, QZERO, QZERO,
          RZERO, TYPED, 1'b0},
        '{CMD_SPHERE, 3'd0, COEF_A, QZERO, QZERO, QZERO, QZERO, QZERO, QZERO, QZERO,
          RZERO, TYPED, 1'b0},
        '{CMD_SPHERE, 3'd0, COEF_A, QZERO, QZERO, QZERO, QZERO, QZERO, QZERO, QZERO,
          RMAX, TYPED, 1'b1},
        '{CMD_BOX_ISECT, 3'd0, COEF_A, QZERO, QMIN, QMIN, QMIN, QMAX, QMAX, QMAX,
          RZERO, TYPED, 1'b0},
        // out-of-range plane loads and unknown commands are dropped
        '{CMD_LOAD, 3'd6, COEF_D, QONE, QZERO, QZERO, QZERO, QZERO, QZERO, QZERO,
          RZERO, BY_PRED, 1'b0},
        '{CMD_LOAD, 3'd7, COEF_D, QONE, QZERO, QZERO, QZERO, QZERO, QZERO, QZERO,
          RZERO, BY_PRED, 1'b0},
        '{CMD_RSVD5, 3'd0, COEF_D, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX,
          RMAX, BY_PRED, 1'b0},
        '{CMD_RSVD6, 3'd7, COEF_B, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN,
          RZERO, BY_PRED, 1'b0},
        '{CMD_RSVD7, 3'd5, COEF_C, QONE, QONE, QONE, QONE, QONE, QONE, QONE,
          RMAX, BY_PRED, 1'b0},
        '{CMD_POINT, 3'd0, COEF_A, QZERO, QZERO, QZERO, QZERO, QZERO, QZERO, QZERO,
          RZERO, TYPED, 1'b0},
        '{CMD_LOAD, 3'd0, COEF_A, QMIN, QZERO, QZERO, QZERO, QZERO, QZERO, QZERO,
          RZERO, BY_PRED, 1'b0},
        '{CMD_POINT, 3'd0, COEF_A, QZERO, QMIN, QZERO, QZERO, QZERO, QZERO, QZERO,
          RZERO, BY_PRED, 1'b0},
        '{CMD_BOX_ISECT, 3'd0, COEF_A, QZERO, QMIN, QMIN, QMIN, QMAX, QMAX, QMAX,
          RZERO, BY_PRED, 1'b0},
        '{CMD_BOX_INSIDE, 3'd0, COEF_A, QZERO, QMIN, QMIN, QMIN, QMAX, QMAX, QMAX,
          RZERO, BY_PRED, 1'b0},
        // reversed box: min above max
        '{CMD_BOX_INSIDE, 3'd0, COEF_A, QZERO, QMAX, QMAX, QMAX, QMIN, QMIN, QMIN,
          RZERO, BY_PRED, 1'b0},
        '{CMD_LOAD, 3'd1, COEF_A, QMIN, QZERO, QZERO, QZERO, QZERO, QZERO, QZERO,
          RZERO, BY_PRED, 1'b0},
        '{CMD_LOAD, 3'd1, COEF_B, QMIN, QZERO, QZERO, QZERO, QZERO, QZERO, QZERO,
          RZERO, BY_PRED, 1'b0},
        '{CMD_LOAD, 3'd1, COEF_C, QMIN, QZERO, QZERO, QZERO, QZERO, QZERO, QZERO,
          RZERO, BY_PRED, 1'b0},
        // sum of three max products overflows 64 bits
        '{CMD_POINT, 3'd0, COEF_A, QZERO, QMIN, QMIN, QMIN, QZERO, QZERO, QZERO,
          RZERO, BY_PRED, 1'b0},
        '{CMD_SPHERE, 3'd0, COEF_A, QZERO, QMAX, QMAX, QMAX, QZERO, QZERO, QZERO,
          RMAX, BY_PRED, 1'b0},
        '{CMD_LOAD, 3'd5, COEF_D, QMAX, QZERO, QZERO, QZERO, QZERO, QZERO, QZERO,
          RZERO, BY_PRED, 1'b0},
        '{CMD_POINT, 3'd0, COEF_A, QZERO, QZERO, QZERO, QZERO, QZERO, QZERO, QZERO,
          RZERO, BY_PRED, 1'b0}
    };

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_valid;
    logic                      o_ready;
    logic [CMD_W-1:0]          i_command;
    logic [PLANE_W-1:0]        i_plane_index;
    logic [CIDX_W-1:0]         i_coef_index;
    logic signed [COEF_W-1:0]  i_coef_value;
    logic signed [COEF_W-1:0]  i_x_a, i_y_a, i_z_a, i_x_b, i_y_b, i_z_b;
    logic [RAD_W-1:0]          i_sphere_radius;
    logic                      o_valid;
    logic                      i_ready;
    logic                      o_visible;

    logic                      row_typed;
    logic                      row_vis;

    logic signed [COEF_W-1:0]  plane_tbl [NUM_PLANES][NUM_COEF];
    bit                        visible_q [$];
    bit                        exp_vis;
    int                        mismatch_cnt;
    int                        verdicts_seen;
    int                        stuck_cycles;

    frustum_plane_cull_test #(.NUM_PLANES(NUM_PLANES)) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_command       (i_command),
        .i_plane_index   (i_plane_index),
        .i_coef_index    (i_coef_index),
        .i_coef_value    (i_coef_value),
        .i_x_a           (i_x_a),
        .i_y_a           (i_y_a),
        .i_z_a           (i_z_a),
        .i_x_b           (i_x_b),
        .i_y_b           (i_y_b),
        .i_z_b           (i_z_b),
        .i_sphere_radius (i_sphere_radius),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_visible       (o_visible)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    task automatic report_mismatch(string msg);
        if (mismatch_cnt < MAX_PRINTS) begin
            $display("MISMATCH @%0t: %s", $time, msg);
        end
        mismatch_cnt++;
    endtask

    // Exact plane value v = a*x + b*y + c*z + (d << 16) + bias, tested for v <= 0.
    function automatic bit plane_rejects(int p, logic signed [COEF_W-1:0] x,
                                         logic signed [COEF_W-1:0] y,
                                         logic signed [COEF_W-1:0] z,
                                         logic signed [127:0] bias);
        logic signed [127:0] wa, wb, wc, wd, wx, wy, wz, sum;
        wa = plane_tbl[p][COEF_A];
        wb = plane_tbl[p][COEF_B];
        wc = plane_tbl[p][COEF_C];
        wd = plane_tbl[p][COEF_D];
        wx = x;
        wy = y;
        wz = z;
        sum = wa * wx + wb * wy + wc * wz + (wd <<< FRAC_W) + bias;
        return sum <= 0;
    endfunction

    function automatic bit predict_visible(logic [CMD_W-1:0] cmd,
                                           logic signed [COEF_W-1:0] xa, ya, za,
                                           logic signed [COEF_W-1:0] xb, yb, zb,
                                           logic [RAD_W-1:0] rad);
        logic signed [127:0] bias;
        logic signed [COEF_W-1:0] cx, cy, cz;
        int outside;
        bit vis;
        vis = 1'b1;
        bias = '0;
        if (cmd == CMD_SPHERE) begin
            bias = {81'd0, rad, 16'd0};
        end
        for (int p = 0; p < NUM_PLANES; p++) begin
            if (cmd == CMD_POINT || cmd == CMD_SPHERE) begin
                if (plane_rejects(p, xa, ya, za, bias)) vis = 1'b0;
            end else begin
                outside = 0;
                for (int k = 0; k < NUM_CORNERS; k++) begin
                    cx = (k & 1) ? xb : xa;
                    cy = (k & 2) ? yb : ya;
                    cz = (k & 4) ? zb : za;
                    if (plane_rejects(p, cx, cy, cz, '0)) outside++;
                end
                if (cmd == CMD_BOX_ISECT && outside == NUM_CORNERS) vis = 1'b0;
                if (cmd == CMD_BOX_INSIDE && outside != 0) vis = 1'b0;
            end
        end
        return vis;
    endfunction

    // Predictor update and verdict check, both on accepted transactions.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                if (i_command == CMD_LOAD) begin
                    if (i_plane_index < NUM_PLANES) begin
                        plane_tbl[i_plane_index][i_coef_index] = i_coef_value;
                    end
                end else if (i_command >= CMD_POINT && i_command <= CMD_BOX_INSIDE) begin
                    if (row_typed) begin
                        visible_q.push_back(row_vis);
                    end else begin
                        visible_q.push_back(predict_visible(i_command, i_x_a, i_y_a, i_z_a,
                                                            i_x_b, i_y_b, i_z_b,
                                                            i_sphere_radius));
                    end
                end
            end
            if (o_valid && i_ready) begin
                verdicts_seen++;
                if (visible_q.size() == 0) begin
                    report_mismatch($sformatf("visible=%b with no verdict pending", o_visible));
                end else begin
                    exp_vis = visible_q.pop_front();
                    if (o_visible !== exp_vis) begin
                        report_mismatch($sformatf("visible=%b, predicted %b",
                                                  o_visible, exp_vis));
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
        if (stuck_cycles >= STALL_LIMIT) begin
            $display("** frustum_plane_cull_test: FAILED **");
            $finish;
        end
    end

    // Output side back-pressure, with two long hold-offs.
    initial begin
        int stall_left;
        int calm_left;
        int hold_left;
        int holds_taken;
        int r;
        stall_left = 0;
        calm_left = 0;
        hold_left = 0;
        holds_taken = 0;
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left == 0 && holds_taken < 2 &&
                verdicts_seen >= (holds_taken == 0 ? 150 : 1000)) begin
                hold_left = LONG_HOLD;
                holds_taken++;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                if (calm_left > 0) begin
                    calm_left--;
                end else begin
                    r = $urandom_range(0, 99);
                    if (r < 3) calm_left = $urandom_range(50, 200);
                    else if (r < 20) stall_left = $urandom_range(1, 3);
                    else if (r < 23) stall_left = $urandom_range(15, 60);
                end
            end
        end
    end

    function automatic logic signed [COEF_W-1:0] near_zero(int unsigned span);
        int v;
        v = int'($urandom_range(0, 2 * span)) - int'(span);
        return v;
    endfunction

    function automatic logic signed [COEF_W-1:0] rand_coord(bit tame);
        int r;
        r = $urandom_range(0, 15);
        if (r == 0) return QMIN;
        if (r == 1) return QMAX;
        if (r < 5 || !tame) return $urandom;
        return near_zero(COORD_SPAN);
    endfunction

    function automatic logic signed [COEF_W-1:0] rand_coef(bit tame, bit is_d);
        int r;
        r = $urandom_range(0, 15);
        if (r == 0) return QMIN;
        if (r == 1) return QMAX;
        if (r == 2 || !tame) return $urandom;
        if (!is_d) return near_zero(COEF_SPAN);
        if (r == 3) return near_zero(COORD_SPAN);
        return $urandom_range(0, D_SPAN);
    endfunction

    function automatic t_cull_txn rand_txn(bit tame);
        t_cull_txn t;
        int r;
        logic [31:0] raw;
        r = $urandom_range(0, 99);
        t.cidx = CIDX_W'($urandom);
        t.plane = PLANE_W'($urandom_range(0, PLANE_TOP));
        if (r < 82) begin
            t.cmd = CMD_W'($urandom_range(CMD_POINT, CMD_BOX_INSIDE));
        end else if (r < 88) begin
            t.cmd = CMD_LOAD;
            t.plane = PLANE_W'($urandom_range(0, NUM_PLANES - 1));
        end else if (r < 94) begin
            t.cmd = CMD_LOAD;
            t.plane = PLANE_W'($urandom_range(NUM_PLANES, PLANE_TOP));
        end else begin
            t.cmd = CMD_W'($urandom_range(CMD_RSVD5, CMD_RSVD7));
        end
        t.coef = rand_coef(tame, t.cidx == COEF_D);
        t.xa = rand_coord(tame);
        t.ya = rand_coord(tame);
        t.za = rand_coord(tame);
        t.xb = rand_coord(tame);
        t.yb = rand_coord(tame);
        t.zb = rand_coord(tame);
        r = $urandom_range(0, 15);
        raw = $urandom;
        if (r == 0) t.rad = RZERO;
        else if (r == 1) t.rad = RMAX;
        else if (r < 5) t.rad = raw[RAD_W-1:0];
        else t.rad = RAD_W'($urandom_range(0, RAD_SPAN));
        return t;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_txn(t_cull_txn t, bit typed, bit vis, int gap);
        @(negedge i_clk);
        i_command       <= t.cmd;
        i_plane_index   <= t.plane;
        i_coef_index    <= t.cidx;
        i_coef_value    <= t.coef;
        i_x_a           <= t.xa;
        i_y_a           <= t.ya;
        i_z_a           <= t.za;
        i_x_b           <= t.xb;
        i_y_b           <= t.yb;
        i_z_b           <= t.zb;
        i_sphere_radius <= t.rad;
        row_typed       <= typed;
        row_vis         <= vis;
        i_valid         <= 1'b1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (visible_q.size() != 0) @(negedge i_clk);
    endtask

    task automatic load_plane(int p, int c, logic signed [COEF_W-1:0] value, int gap);
        t_cull_txn t;
        t = rand_txn(1'b1);
        t.cmd = CMD_LOAD;
        t.plane = PLANE_W'(p);
        t.cidx = CIDX_W'(c);
        t.coef = value;
        send_txn(t, 1'b0, 1'b0, gap);
    endtask

    initial begin
        t_cull_txn t;
        int counted;
        int r;
        bit tame;
        bit no_gaps;
        bit first_phase;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_command = CMD_LOAD;
        i_plane_index = '0;
        i_coef_index = COEF_A;
        i_coef_value = '0;
        i_x_a = '0;
        i_y_a = '0;
        i_z_a = '0;
        i_x_b = '0;
        i_y_b = '0;
        i_z_b = '0;
        i_sphere_radius = '0;
        row_typed = 1'b0;
        row_vis = 1'b0;
        mismatch_cnt = 0;
        verdicts_seen = 0;
        stuck_cycles = 0;
        foreach (plane_tbl[p, c]) plane_tbl[p][c] = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // every plane is written before the first test
        for (int p = 0; p < NUM_PLANES; p++) begin
            for (int c = 0; c < NUM_COEF; c++) begin
                load_plane(p, c, (c == COEF_D) ? QONE : QZERO, pick_gap());
            end
        end

        foreach (dir_tbl[i]) begin
            t.cmd   = dir_tbl[i].cmd;
            t.plane = dir_tbl[i].plane;
            t.cidx  = dir_tbl[i].cidx;
            t.coef  = dir_tbl[i].coef;
            t.xa    = dir_tbl[i].xa;
            t.ya    = dir_tbl[i].ya;
            t.za    = dir_tbl[i].za;
            t.xb    = dir_tbl[i].xb;
            t.yb    = dir_tbl[i].yb;
            t.zb    = dir_tbl[i].zb;
            t.rad   = dir_tbl[i].rad;
            send_txn(t, dir_tbl[i].chk == TYPED, dir_tbl[i].vis, pick_gap());
        end
        wait_drained();

        counted = 0;
        first_phase = 1'b1;
        while (counted < RAND_ITEMS) begin
            tame = $urandom_range(0, 4) != 0;
            no_gaps = $urandom_range(0, 3) == 0;
            r = $urandom_range(0, 9);
            if (r < 4) begin
                for (int p = 0; p < NUM_PLANES; p++) begin
                    for (int c = 0; c < NUM_COEF; c++) begin
                        load_plane(p, c, rand_coef(tame, c == COEF_D),
                                   no_gaps ? 0 : pick_gap());
                        counted++;
                    end
                end
            end else if (r < 8) begin
                repeat ($urandom_range(1, 6)) begin
                    r = $urandom_range(0, NUM_COEF - 1);
                    load_plane($urandom_range(0, NUM_PLANES - 1), r,
                               rand_coef(tame, r == COEF_D), no_gaps ? 0 : pick_gap());
                    counted++;
                end
            end
            repeat ($urandom_range(20, 60)) begin
                t = rand_txn(tame);
                counted++;
                send_txn(t, 1'b0, 1'b0, no_gaps ? 0 : pick_gap());
            end
            if (first_phase || $urandom_range(0, 3) == 0) begin
                wait_drained();
            end
            first_phase = 1'b0;
        end

        wait_drained();
        repeat (4 * LATENCY) @(posedge i_clk);
        if (visible_q.size() != 0) begin
            report_mismatch($sformatf("%0d verdicts never arrived", visible_q.size()));
        end
        if (mismatch_cnt == 0) begin
            $display("** frustum_plane_cull_test: PASSED **");
        end else begin
            $display("** frustum_plane_cull_test: FAILED **");
        end
        $finish;
    end

endmodule
